// ===== rtl/core/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the two-class priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int QueueDepth = 128;
  localparam int PtrBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int AgeBits    = 7;
  localparam int TagBits    = 16;
  localparam int StatusBits = 3;

  localparam logic [AgeBits-1:0] ThreshReset = AgeBits'(60);

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_QUEUED_PRIO = 3'd0,
    ST_QUEUED_REG  = 3'd1,
    ST_DROPPED     = 3'd2,
    ST_SERVED_PRIO = 3'd3,
    ST_SERVED_REG  = 3'd4,
    ST_NOTHING     = 3'd5
  } status_e;

  typedef struct packed {
    logic [AgeBits-1:0] age;
    logic [TagBits-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/two_class_priority_queue_core.sv =====
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls, set by the single
// result register and the one write port and one registered read port of each
// queue memory. Reset clears both queues' heads and counts and the output
// valid, and loads the age threshold with 60; queue memories are not cleared.
// ----------------------------------------------------------------------------
// two_class_priority_queue_core
// Strict-priority queue with two FIFO classes chosen by an age threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue_core
  import tcpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [AgeBits-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [0:0]            operation_i,
  input  logic [AgeBits-1:0]    entry_age_i,
  input  logic [TagBits-1:0]    entry_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StatusBits-1:0] status_o,
  output logic [AgeBits-1:0]    served_age_o,
  output logic [TagBits-1:0]    served_tag_o
);

  logic [AgeBits-1:0] thresh_q;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic               accept;
  logic               is_serve;
  logic               is_prio;
  logic               push_prio, push_reg, pop_prio, pop_reg;
  entry_t             new_entry;
  entry_t             prio_rd, reg_rd;
  ring_stat_t         prio_stat, reg_stat;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_serve   = (op_e'(operation_i) == OP_SERVE);
  assign is_prio    = (entry_age_i >= thresh_q);
  assign new_entry  = '{age: entry_age_i, tag: entry_tag_i};

  assign push_prio = accept && !is_serve && is_prio && !prio_stat.full;
  assign push_reg  = accept && !is_serve && !is_prio && !reg_stat.full;
  assign pop_prio  = accept && is_serve && !prio_stat.empty;
  assign pop_reg   = accept && is_serve && prio_stat.empty && !reg_stat.empty;

  always_comb begin
    if (is_serve) begin
      if (!prio_stat.empty) begin
        status_d = ST_SERVED_PRIO;
      end else if (!reg_stat.empty) begin
        status_d = ST_SERVED_REG;
      end else begin
        status_d = ST_NOTHING;
      end
    end else if (is_prio) begin
      status_d = prio_stat.full ? ST_DROPPED : ST_QUEUED_PRIO;
    end else begin
      status_d = reg_stat.full ? ST_DROPPED : ST_QUEUED_REG;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= ThreshReset;
      out_valid_q <= 1'b0;
      status_q    <= ST_NOTHING;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  tcpq_ring u_prio_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_prio),
    .push_data_i (new_entry),
    .pop_i       (pop_prio),
    .pop_data_o  (prio_rd),
    .stat_o      (prio_stat)
  );

  tcpq_ring u_reg_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_reg),
    .push_data_i (new_entry),
    .pop_i       (pop_reg),
    .pop_data_o  (reg_rd),
    .stat_o      (reg_stat)
  );

  always_comb begin
    case (status_q)
      ST_SERVED_PRIO: begin
        served_age_o = prio_rd.age;
        served_tag_o = prio_rd.tag;
      end
      ST_SERVED_REG: begin
        served_age_o = reg_rd.age;
        served_tag_o = reg_rd.tag;
      end
      default: begin
        served_age_o = '0;
        served_tag_o = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/tcpq_ring.sv =====
// ----------------------------------------------------------------------------
// tcpq_ring
// Ring-buffer FIFO with a head pointer, a fill count and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ring
  import tcpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     push_data_i,
  input  logic       pop_i,
  output entry_t     pop_data_o,
  output ring_stat_t stat_o
);

  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QueueDepth - 1);
  localparam logic [CntBits-1:0] DepthCnt = CntBits'(QueueDepth);

  entry_t               mem_q [QueueDepth];
  entry_t               rd_q;
  logic [PtrBits-1:0]   head_q, head_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic [CntBits:0]     tail_sum;
  logic [CntBits:0]     tail_wrap;
  logic [PtrBits-1:0]   tail;

  always_comb begin
    tail_sum  = (CntBits+1)'(head_q) + (CntBits+1)'(count_q);
    tail_wrap = tail_sum - (CntBits+1)'(DepthCnt);
    if (tail_sum >= (CntBits+1)'(DepthCnt)) begin
      tail = tail_wrap[PtrBits-1:0];
    end else begin
      tail = tail_sum[PtrBits-1:0];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_i) begin
      head_d  = (head_q == LastPtr) ? '0 : head_q + PtrBits'(1);
      count_d = count_q - CntBits'(1);
    end else if (push_i) begin
      count_d = count_q + CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail] <= push_data_i;
    end
    if (pop_i) begin
      rd_q <= mem_q[head_q];
    end
  end

  assign pop_data_o   = rd_q;
  assign stat_o.full  = (count_q == DepthCnt);
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/tcpq_checker.sv =====
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks for the two-class priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_checker
  import tcpq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [StatusBits-1:0] status_o,
  input logic [AgeBits-1:0]    served_age_o,
  input logic [TagBits-1:0]    served_tag_o
);

  // Only a served word carries entry data.
  a_zero_unless_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_SERVED_PRIO && status_o != ST_SERVED_REG
    |-> served_age_o == '0 && served_tag_o == '0)
    else $error("Served fields nonzero on a word that serves nothing.");

  // A stalled result word holds.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
    |=> out_valid_o && $stable(status_o) && $stable(served_age_o)
        && $stable(served_tag_o))
    else $error("Stalled result word changed.");

  // No result word appears without an accepted input word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) && (!out_valid_o || out_ready_i)
    |=> !out_valid_o)
    else $error("Result word appeared without an accepted input word.");

  // Every accepted word yields a result word in the next cycle.
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("Accepted word gave no result in the next cycle.");

endmodule

bind two_class_priority_queue_core tcpq_checker u_tcpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .served_age_o (served_age_o),
  .served_tag_o (served_tag_o)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the two-class priority queue core.
// A predictor mirrors both FIFO classes and the age threshold and tracks
// every accepted word. Results are checked in order under random idling on
// both sides, long output stalls, queue-full drops and empty-queue serves.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import tcpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldOffCycles = 300;

  class priority_queue_predictor;
    localparam int PrioClass = 0;
    localparam int RegClass  = 1;
    localparam int NoClass   = -1;

    typedef struct {
      status_e            status;
      logic [AgeBits-1:0] age;
      logic [TagBits-1:0] tag;
    } outcome_t;

    entry_t             ring [2][QueueDepth];
    int unsigned        head [2];
    int unsigned        fill [2];
    logic [AgeBits-1:0] threshold;
    outcome_t           due_outcomes [$];
    int unsigned        mismatches;

    function void clear();
      head[PrioClass] = 0;
      head[RegClass]  = 0;
      fill[PrioClass] = 0;
      fill[RegClass]  = 0;
      threshold       = ThreshReset;
      due_outcomes.delete();
      mismatches      = 0;
    endfunction

    function void set_threshold(logic [AgeBits-1:0] value);
      threshold = value;
    endfunction

    function int unsigned pending_count();
      return due_outcomes.size();
    endfunction

    function void note_word(op_e op, logic [AgeBits-1:0] age, logic [TagBits-1:0] tag);
      outcome_t o;
      int       cls;
      o.status = ST_NOTHING;
      o.age    = '0;
      o.tag    = '0;
      if (op == OP_ENQUEUE) begin
        cls = (age >= threshold) ? PrioClass : RegClass;
        if (fill[cls] == QueueDepth) begin
          o.status = ST_DROPPED;
        end else begin
          ring[cls][(head[cls] + fill[cls]) % QueueDepth].age = age;
          ring[cls][(head[cls] + fill[cls]) % QueueDepth].tag = tag;
          fill[cls]++;
          o.status = (cls == PrioClass) ? ST_QUEUED_PRIO : ST_QUEUED_REG;
        end
      end else begin
        if (fill[PrioClass] != 0) begin
          cls = PrioClass;
        end else if (fill[RegClass] != 0) begin
          cls = RegClass;
        end else begin
          cls = NoClass;
        end
        if (cls != NoClass) begin
          o.age     = ring[cls][head[cls]].age;
          o.tag     = ring[cls][head[cls]].tag;
          head[cls] = (head[cls] + 1) % QueueDepth;
          fill[cls]--;
          o.status  = (cls == PrioClass) ? ST_SERVED_PRIO : ST_SERVED_REG;
        end
      end
      due_outcomes.push_back(o);
    endfunction

    function void check_word(logic [StatusBits-1:0] status, logic [AgeBits-1:0] age,
                             logic [TagBits-1:0] tag);
      outcome_t o;
      if (due_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0d age %0d tag 0x%04h",
                 $time, status, age, tag);
      end else begin
        o = due_outcomes.pop_front();
        if (status !== o.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d actual %0d", $time, o.status, status);
        end
        if (age !== o.age) begin
          mismatches++;
          $display("%0t: served_age mismatch, expected %0d actual %0d", $time, o.age, age);
        end
        if (tag !== o.tag) begin
          mismatches++;
          $display("%0t: served_tag mismatch, expected 0x%04h actual 0x%04h",
                   $time, o.tag, tag);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [AgeBits-1:0]    cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [0:0]            operation_i;
  logic [AgeBits-1:0]    entry_age_i;
  logic [TagBits-1:0]    entry_tag_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [StatusBits-1:0] status_o;
  logic [AgeBits-1:0]    served_age_o;
  logic [TagBits-1:0]    served_tag_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;

  priority_queue_predictor sb = new;

  two_class_priority_queue_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .entry_age_i  (entry_age_i),
    .entry_tag_i  (entry_tag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .served_age_o (served_age_o),
    .served_tag_o (served_tag_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(status_o, served_age_o, served_tag_o);
    end
  end

  task automatic send_word(op_e op, logic [AgeBits-1:0] age, logic [TagBits-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    entry_age_i <= age;
    entry_tag_i <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, age, tag);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [AgeBits-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_threshold(value);
  endtask

  task automatic run_phase(int unsigned count, int unsigned enq_pct);
    op_e op;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_SERVE;
      send_word(op, AgeBits'($urandom_range(127)), TagBits'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_ENQUEUE;
    entry_age_i = '0;
    entry_tag_i = '0;
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_SERVE, '0, '0);
    send_word(OP_ENQUEUE, 7'd0, 16'h0000);
    send_word(OP_ENQUEUE, 7'd127, 16'hFFFF);
    send_word(OP_ENQUEUE, 7'd59, 16'h5555);
    send_word(OP_ENQUEUE, 7'd60, 16'hAAAA);
    repeat (5) send_word(OP_SERVE, 7'd127, 16'hFFFF);
    wait_drained();
    write_threshold(7'd0);
    send_word(OP_ENQUEUE, 7'd0, 16'h0001);
    wait_drained();
    write_threshold(7'd127);
    send_word(OP_ENQUEUE, 7'd126, 16'h8000);
    send_word(OP_ENQUEUE, 7'd127, 16'h7FFF);
    repeat (4) send_word(OP_SERVE, '0, '0);
    wait_drained();

    write_threshold(ThreshReset);
    run_phase(100, 50);
    wait_drained();

    write_threshold(7'd0);
    send_idle_pct = 85;
    run_phase(200, 90);
    wait_drained();

    write_threshold(7'd127);
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    hold_off_req   = 1'b1;
    run_phase(200, 90);
    wait_drained();

    write_threshold(AgeBits'($urandom_range(1, 126)));
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    run_phase(350, 10);
    wait_drained();

    write_threshold(ThreshReset);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(100, 50);
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
